// File: rtl/tch_pkg.sv
// ----------------------------------------------------------------------------
// tch_pkg
// Shared constants and the arctangent table for the tilt-compensated heading
// pipeline.
// ----------------------------------------------------------------------------
package tch_pkg;

    localparam int GUARD_BITS = 6;
    localparam int HEAD_BITS  = 3;
    localparam int ANGLE_W    = 34;
    localparam int TABLE_LEN  = 24;
    localparam int HEADING_W  = 15;
    localparam int INCL_W     = 14;
    localparam int ROLL_W     = 15;
    localparam int DEG_W      = ANGLE_W + 16 - 32;

    localparam logic signed [ANGLE_W-1:0] QUARTER_A = ANGLE_W'(64'sd1073741824);
    localparam logic signed [ANGLE_W-1:0] HALF_A    = ANGLE_W'(64'sd2147483648);
    localparam logic signed [ANGLE_W-1:0] TURN_A    = ANGLE_W'(64'sd4294967296);
    localparam logic [29:0]               INV_GAIN  = 30'd652032874;
    localparam logic signed [15:0]        DEG_SCALE = 16'sd23040;
    localparam logic signed [DEG_W-1:0]   LIM_HALF  = DEG_W'(11520);
    localparam logic signed [DEG_W-1:0]   LIM_QUART = DEG_W'(5760);

    function automatic logic [31:0] atan_tab(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/tch_cordic.sv
// ----------------------------------------------------------------------------
// tch_cordic
// Pipelined CORDIC, one iteration per register stage, vectoring or rotating,
// with a sideband carried alongside the data.
// ----------------------------------------------------------------------------
module tch_cordic #(
    parameter int DW     = 25,
    parameter int STEPS  = 16,
    parameter int SBW    = 1,
    parameter bit ROTATE = 1'b0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [DW-1:0]               x_i,
    input  logic signed [DW-1:0]               y_i,
    input  logic signed [tch_pkg::ANGLE_W-1:0] z_i,
    input  logic [SBW-1:0]                     sb_i,
    output logic                               out_valid,
    output logic signed [DW-1:0]               x_o,
    output logic signed [DW-1:0]               y_o,
    output logic signed [tch_pkg::ANGLE_W-1:0] z_o,
    output logic [SBW-1:0]                     sb_o
);
    import tch_pkg::*;

    logic signed [DW-1:0]      x_reg  [0:STEPS];
    logic signed [DW-1:0]      y_reg  [0:STEPS];
    logic signed [ANGLE_W-1:0] z_reg  [0:STEPS];
    logic                      zf_reg [0:STEPS];
    logic                      v_reg  [0:STEPS];
    logic [SBW-1:0]            sb_reg [0:STEPS];

    logic signed [DW-1:0]      x_next;
    logic signed [DW-1:0]      y_next;
    logic signed [ANGLE_W-1:0] z_next;
    logic                      zf_next;

    // quadrant fold
    always_comb begin
        x_next  = x_i;
        y_next  = y_i;
        z_next  = z_i;
        zf_next = 1'b0;
        if (ROTATE) begin
            if (z_i > QUARTER_A) begin
                x_next = -y_i;
                y_next = x_i;
                z_next = z_i - QUARTER_A;
            end else if (z_i < -QUARTER_A) begin
                x_next = y_i;
                y_next = -x_i;
                z_next = z_i + QUARTER_A;
            end
        end else begin
            zf_next = (x_i == '0) && (y_i == '0);
            z_next  = '0;
            if (x_i < 0) begin
                if (y_i >= 0) begin
                    x_next = y_i;
                    y_next = -x_i;
                    z_next = QUARTER_A;
                end else begin
                    x_next = -y_i;
                    y_next = x_i;
                    z_next = -QUARTER_A;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]  <= x_next;
            y_reg[0]  <= y_next;
            z_reg[0]  <= z_next;
            zf_reg[0] <= zf_next;
            sb_reg[0] <= sb_i;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_iter
        logic signed [DW-1:0]      dx;
        logic signed [DW-1:0]      dy;
        logic signed [ANGLE_W-1:0] t;
        logic                      d;
        logic signed [DW-1:0]      xs_next;
        logic signed [DW-1:0]      ys_next;
        logic signed [ANGLE_W-1:0] zs_next;

        always_comb begin
            dx = y_reg[k] >>> k;
            dy = x_reg[k] >>> k;
            t  = $signed({{(ANGLE_W-32){1'b0}}, atan_tab(k)});
            d  = ROTATE ? (z_reg[k] >= 0) : (y_reg[k] >= 0);
            if (ROTATE == d) begin
                xs_next = x_reg[k] - dx;
                ys_next = y_reg[k] + dy;
            end else begin
                xs_next = x_reg[k] + dx;
                ys_next = y_reg[k] - dy;
            end
            if (d ^ ROTATE) begin
                zs_next = z_reg[k] + t;
            end else begin
                zs_next = z_reg[k] - t;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k+1]  <= xs_next;
                y_reg[k+1]  <= ys_next;
                z_reg[k+1]  <= zs_next;
                zf_reg[k+1] <= zf_reg[k];
                sb_reg[k+1] <= sb_reg[k];
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign x_o       = x_reg[STEPS];
    assign y_o       = y_reg[STEPS];
    assign z_o       = zf_reg[STEPS] ? '0 : z_reg[STEPS];
    assign sb_o      = sb_reg[STEPS];

endmodule

// File: rtl/tilt_compensated_heading.sv
// ----------------------------------------------------------------------------
// tilt_compensated_heading
// Tilt-compensated compass: roll, inclination and heading from one gravity
// and one magnetic vector, as a fully pipelined CORDIC chain.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                  | handshake
//  s_      | in        | grav_x/y/z, mag_x/y/z                  | s_valid/s_ready
//  m_      | out       | heading/inclination/roll_deg, grav_zero| m_valid/m_ready
//
//  One item per cycle when not stalled; the path runs through four CORDIC
//  chains in series (two gain multiplies, degree conversion and output stages).
//  Synchronous active-low reset clears the valid bits only.
//  A stall on m_ready freezes the whole pipeline; s_ready follows it.
// ----------------------------------------------------------------------------
module tilt_compensated_heading #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_grav_x,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_grav_y,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_grav_z,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_mag_x,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_mag_y,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_mag_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [tch_pkg::HEADING_W-1:0] m_heading_deg,
    output logic signed [tch_pkg::INCL_W-1:0]    m_inclination_deg,
    output logic signed [tch_pkg::ROLL_W-1:0]    m_roll_deg,
    output logic                                 m_gravity_zero
);
    import tch_pkg::*;

    localparam int DW    = SAMPLE_WIDTH + GUARD_BITS + HEAD_BITS;
    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int PW    = DW + 31;
    localparam int SB1_W = 4 * DW + 1;
    localparam int SB4_W = DW + 2 * ANGLE_W + 1;
    localparam int SB5_W = 2 * ANGLE_W + 1;

    function automatic logic signed [DW-1:0] scale(input logic signed [SAMPLE_WIDTH-1:0] s);
        return {{HEAD_BITS{s[SAMPLE_WIDTH-1]}}, s, {GUARD_BITS{1'b0}}};
    endfunction

    function automatic logic signed [DW-1:0] remove_gain(input logic signed [DW-1:0] v);
        logic signed [PW-1:0] p;
        p = $signed({{(PW-DW){v[DW-1]}}, v}) * $signed({{(PW-30){1'b0}}, INV_GAIN});
        p = p + $signed(PW'(64'd536870912));
        p = p >>> 30;
        return p[DW-1:0];
    endfunction

    function automatic logic signed [DEG_W-1:0] to_deg(input logic signed [ANGLE_W-1:0] a);
        logic signed [ANGLE_W-1:0]    w;
        logic signed [ANGLE_W+15:0]   p;
        w = a;
        if (w > HALF_A) w = w - TURN_A;
        if (w < -HALF_A) w = w + TURN_A;
        p = $signed({{16{w[ANGLE_W-1]}}, w}) * $signed({{ANGLE_W{1'b0}}, DEG_SCALE});
        p = p + $signed((ANGLE_W+16)'(64'd2147483648));
        p = p >>> 32;
        return p[DEG_W-1:0];
    endfunction

    function automatic logic signed [DEG_W-1:0] clamp(input logic signed [DEG_W-1:0] d,
                                                      input logic signed [DEG_W-1:0] lim);
        if (d > lim) return lim;
        if (d < -lim) return -lim;
        return d;
    endfunction

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // roll = atan2(gy, gz)
    logic                      c1_valid;
    logic signed [DW-1:0]      c1_mag;
    logic signed [ANGLE_W-1:0] c1_roll;
    logic [SB1_W-1:0]          c1_sb;
    logic                      s_gzero;

    assign s_gzero = (s_grav_x == '0) && (s_grav_y == '0) && (s_grav_z == '0);

    tch_cordic #(.DW(DW), .STEPS(STEPS), .SBW(SB1_W), .ROTATE(1'b0)) u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .x_i       (scale(s_grav_z)),
        .y_i       (scale(s_grav_y)),
        .z_i       ('0),
        .sb_i      ({scale(s_grav_x), scale(s_mag_x), scale(s_mag_y), scale(s_mag_z),
                     s_gzero}),
        .out_valid (c1_valid),
        .x_o       (c1_mag),
        .y_o       (),
        .z_o       (c1_roll),
        .sb_o      (c1_sb)
    );

    // gain removal on the y-z magnitude
    logic                      b_valid_reg;
    logic signed [DW-1:0]      b_r_reg;
    logic signed [DW-1:0]      b_gx_reg;
    logic signed [DW-1:0]      b_mx_reg;
    logic signed [DW-1:0]      b_my_reg;
    logic signed [DW-1:0]      b_mz_reg;
    logic signed [ANGLE_W-1:0] b_roll_reg;
    logic                      b_gzero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= c1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_r_reg     <= remove_gain(c1_mag);
            b_gx_reg    <= c1_sb[4*DW:3*DW+1];
            b_mx_reg    <= c1_sb[3*DW:2*DW+1];
            b_my_reg    <= c1_sb[2*DW:DW+1];
            b_mz_reg    <= c1_sb[DW:1];
            b_roll_reg  <= c1_roll;
            b_gzero_reg <= c1_sb[0];
        end
    end

    // inclination = atan2(gx, r), in parallel with the roll rotation of m
    logic                      c2_valid;
    logic signed [ANGLE_W-1:0] c2_incl;
    logic [DW:0]               c2_sb;
    logic                      c3_valid;
    logic signed [DW-1:0]      c3_yp;
    logic signed [DW-1:0]      c3_zp;
    logic signed [ANGLE_W-1:0] c3_roll;

    tch_cordic #(.DW(DW), .STEPS(STEPS), .SBW(DW + 1), .ROTATE(1'b0)) u_incl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b_valid_reg),
        .x_i       (b_r_reg),
        .y_i       (b_gx_reg),
        .z_i       ('0),
        .sb_i      ({b_mx_reg, b_gzero_reg}),
        .out_valid (c2_valid),
        .x_o       (),
        .y_o       (),
        .z_o       (c2_incl),
        .sb_o      (c2_sb)
    );

    tch_cordic #(.DW(DW), .STEPS(STEPS), .SBW(ANGLE_W), .ROTATE(1'b1)) u_derotate_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b_valid_reg),
        .x_i       (b_my_reg),
        .y_i       (b_mz_reg),
        .z_i       (-b_roll_reg),
        .sb_i      (b_roll_reg),
        .out_valid (c3_valid),
        .x_o       (c3_yp),
        .y_o       (c3_zp),
        .z_o       (),
        .sb_o      (c3_roll)
    );

    // gain removal on z'
    logic                      d_valid_reg;
    logic signed [DW-1:0]      d_zc_reg;
    logic signed [DW-1:0]      d_yp_reg;
    logic signed [DW-1:0]      d_mx_reg;
    logic signed [ANGLE_W-1:0] d_incl_reg;
    logic signed [ANGLE_W-1:0] d_roll_reg;
    logic                      d_gzero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= c2_valid && c3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_zc_reg    <= remove_gain(c3_zp);
            d_yp_reg    <= c3_yp;
            d_mx_reg    <= c2_sb[DW:1];
            d_incl_reg  <= c2_incl;
            d_roll_reg  <= c3_roll;
            d_gzero_reg <= c2_sb[0];
        end
    end

    // rotate (mx, zc) by -inclination
    logic                      c4_valid;
    logic signed [DW-1:0]      c4_xpp;
    logic [SB4_W-1:0]          c4_sb;

    tch_cordic #(.DW(DW), .STEPS(STEPS), .SBW(SB4_W), .ROTATE(1'b1)) u_derotate_incl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid_reg),
        .x_i       (d_mx_reg),
        .y_i       (d_zc_reg),
        .z_i       (-d_incl_reg),
        .sb_i      ({d_yp_reg, d_incl_reg, d_roll_reg, d_gzero_reg}),
        .out_valid (c4_valid),
        .x_o       (c4_xpp),
        .y_o       (),
        .z_o       (),
        .sb_o      (c4_sb)
    );

    // heading = atan2(y', x'')
    logic                      c5_valid;
    logic signed [ANGLE_W-1:0] c5_head;
    logic [SB5_W-1:0]          c5_sb;

    tch_cordic #(.DW(DW), .STEPS(STEPS), .SBW(SB5_W), .ROTATE(1'b0)) u_heading (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c4_valid),
        .x_i       (c4_xpp),
        .y_i       (c4_sb[SB4_W-1:SB5_W]),
        .z_i       ('0),
        .sb_i      (c4_sb[SB5_W-1:0]),
        .out_valid (c5_valid),
        .x_o       (),
        .y_o       (),
        .z_o       (c5_head),
        .sb_o      (c5_sb)
    );

    // binary angle to 1/64 degree
    logic                    g_valid_reg;
    logic signed [DEG_W-1:0] g_head_reg;
    logic signed [DEG_W-1:0] g_incl_reg;
    logic signed [DEG_W-1:0] g_roll_reg;
    logic                    g_gzero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (en) begin
            g_valid_reg <= c5_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_head_reg  <= to_deg(c5_head);
            g_incl_reg  <= to_deg(c5_sb[SB5_W-1:ANGLE_W+1]);
            g_roll_reg  <= to_deg(c5_sb[ANGLE_W:1]);
            g_gzero_reg <= c5_sb[0];
        end
    end

    // clamp and output register
    logic                    m_valid_reg;
    logic signed [DEG_W-1:0] head_c;
    logic signed [DEG_W-1:0] incl_c;
    logic signed [DEG_W-1:0] roll_c;

    assign head_c = g_gzero_reg ? '0 : clamp(g_head_reg, LIM_HALF);
    assign incl_c = g_gzero_reg ? '0 : clamp(g_incl_reg, LIM_QUART);
    assign roll_c = g_gzero_reg ? '0 : clamp(g_roll_reg, LIM_HALF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_heading_deg     <= head_c[HEADING_W-1:0];
            m_inclination_deg <= incl_c[INCL_W-1:0];
            m_roll_deg        <= roll_c[ROLL_W-1:0];
            m_gravity_zero    <= g_gzero_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
